/* hw/rtl/gbi_pkg.sv */
// Shared constants, types and codes of the grid bilinear interpolator.
`default_nettype none
package gbi_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_BITS   = 12;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int CNT_BITS    = 7;
  localparam int COORD_BITS  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_BITS    = $clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS);
  localparam int DIV_STAGES  = IDX_BITS + 1 + FRAC_BITS;
  localparam int REM_BITS    = COORD_BITS + IDX_BITS;
  localparam int W_BITS      = 2 * FRAC_BITS + 1;
  localparam int ENTRY_BITS  = 4 * VALUE_BITS;
  localparam int ACC_BITS    = VALUE_BITS + 2 * FRAC_BITS;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [ADDR_BITS-1:0]              addr_t;
  typedef logic [CNT_BITS-1:0]               cnt_t;
  typedef logic [COORD_BITS-1:0]             coord_t;
  typedef logic [IDX_BITS-1:0]               idx_t;
  typedef logic [FRAC_BITS-1:0]              frac_t;
  typedef logic [FRAC_BITS:0]                half_t;
  typedef logic [W_BITS-1:0]                 weight_t;
  typedef logic [3:0][VALUE_BITS-1:0]        entry_t;
  typedef logic [ACC_BITS-1:0]               acc_t;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_BILINEAR = 3'd1,
    ST_LINEAR   = 3'd2,
    ST_SINGLE   = 3'd3,
    ST_NO_DATA  = 3'd4
  } status_t;

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RADIUS_ORIGIN = 3'd0,
    CFG_RADIUS_STEP   = 3'd1,
    CFG_RADIUS_COUNT  = 3'd2,
    CFG_ANGLE_ORIGIN  = 3'd3,
    CFG_ANGLE_STEP    = 3'd4,
    CFG_ANGLE_COUNT   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic  over;
    idx_t  idx;
    frac_t frac;
  } div_res_t;

  typedef struct packed {
    func_t  func;
    addr_t  addr;
    entry_t vals;
    logic   bad_r;
    logic   bad_c;
  } item_t;

endpackage
`default_nettype wire

/* hw/rtl/gbi_ram.sv */
// Generic single write, single registered read RAM.
`default_nettype none
module gbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gbi_divider.sv */
// Pipelined restoring divider giving cell index, range flag and fraction.
`default_nettype none
module gbi_divider (
  input  logic              clk,
  input  logic              en,
  input  gbi_pkg::coord_t   dividend,
  input  gbi_pkg::coord_t   divisor,
  output gbi_pkg::div_res_t res
);
  import gbi_pkg::*;

  logic [REM_BITS-1:0]   rem_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [REM_BITS-1:0]   rem_in;
    logic [REM_BITS-1:0]   trial;
    logic [REM_BITS-1:0]   sub;
    logic [DIV_STAGES-1:0] quo_in;
    logic                  take;

    if (s == 0) begin : g_first
      assign rem_in = REM_BITS'(dividend);
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // index bits: compare against shifted divisor; fraction bits: shift remainder
    if (s <= IDX_BITS) begin : g_idx
      assign trial = rem_in;
      assign sub   = REM_BITS'(divisor) << (IDX_BITS - s);
    end else begin : g_frac
      assign trial = rem_in << 1;
      assign sub   = REM_BITS'(divisor);
    end

    assign take = (trial >= sub);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? (trial - sub) : trial;
        quo_q[s] <= {quo_in[DIV_STAGES-2:0], take};
      end
    end
  end

  assign res = div_res_t'(quo_q[DIV_STAGES-1]);

endmodule
`default_nettype wire

/* hw/rtl/gbi_blend.sv */
// Four-corner weighted sum with round to nearest, for one value lane.
`default_nettype none
module gbi_blend (
  input  logic                                       clk,
  input  logic                                       en,
  input  gbi_pkg::weight_t [3:0]                     w,
  input  logic [3:0][gbi_pkg::VALUE_BITS-1:0]        v,
  output logic [gbi_pkg::VALUE_BITS-1:0]             y
);
  import gbi_pkg::*;

  localparam acc_t ROUND = acc_t'(1) << (2 * FRAC_BITS - 1);

  acc_t prod [4];
  acc_t pair [2];
  acc_t sum;

  for (genvar k = 0; k < 4; k++) begin : g_mul
    logic signed [W_BITS+VALUE_BITS:0] full;
    assign full = $signed({1'b0, w[k]}) * $signed(v[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= full[ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair[0] <= prod[0] + prod[1];
      pair[1] <= prod[2] + prod[3];
    end
  end

  // weights sum to one, so the total never leaves the value range
  assign sum = pair[0] + pair[1] + ROUND;
  assign y   = sum[ACC_BITS-1:2*FRAC_BITS];

endmodule
`default_nettype wire

/* hw/rtl/grid_bilinear_interpolator.sv */
// Top level of the grid bilinear interpolator.
//
//  channel  | handshake              | word
//  ---------+------------------------+---------------------------------------------
//  item     | item_valid/item_stall  | func, entry_address, load_*, query_*
//  result   | result_valid/result_stall | status, log_density, slope_*
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One word enters per cycle while no result is stalled; each result passes the input
// stage, the 23 divider stages (one quotient bit each), address and weight stages,
// the registered grid read, the two blend stages and the result register.
// Reset clears valid bits and loads register defaults; the grid is not cleared.
// A stalled result freezes the whole pipeline, and item_stall follows it.
`default_nettype none
module grid_bilinear_interpolator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic                                   func,
  input  logic [gbi_pkg::ADDR_BITS-1:0]          entry_address,
  input  logic signed [gbi_pkg::VALUE_BITS-1:0]  load_log_density,
  input  logic signed [gbi_pkg::VALUE_BITS-1:0]  load_slope_radius,
  input  logic signed [gbi_pkg::VALUE_BITS-1:0]  load_slope_colat,
  input  logic signed [gbi_pkg::VALUE_BITS-1:0]  load_slope_long,
  input  logic [gbi_pkg::COORD_BITS-1:0]         query_radius,
  input  logic [gbi_pkg::COORD_BITS-1:0]         query_colat,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic [2:0]                             status,
  output logic signed [gbi_pkg::VALUE_BITS-1:0]  log_density,
  output logic signed [gbi_pkg::VALUE_BITS-1:0]  slope_radius,
  output logic signed [gbi_pkg::VALUE_BITS-1:0]  slope_colat,
  output logic signed [gbi_pkg::VALUE_BITS-1:0]  slope_long,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gbi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [gbi_pkg::COORD_BITS-1:0]         cfg_data
);
  import gbi_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam half_t ONE_FRAC = half_t'(1) << FRAC_BITS;

  // configuration registers
  coord_t radius_origin, radius_step, angle_origin, angle_step;
  cnt_t   radius_count, angle_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_origin <= '0;
      radius_step   <= coord_t'(1);
      radius_count  <= cnt_t'(64);
      angle_origin  <= '0;
      angle_step    <= coord_t'(1);
      angle_count   <= cnt_t'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RADIUS_ORIGIN: radius_origin <= cfg_data;
        CFG_RADIUS_STEP:   radius_step   <= cfg_data;
        CFG_RADIUS_COUNT:  radius_count  <= cfg_data[CNT_BITS-1:0];
        CFG_ANGLE_ORIGIN:  angle_origin  <= cfg_data;
        CFG_ANGLE_STEP:    angle_step    <= cfg_data;
        CFG_ANGLE_COUNT:   angle_count   <= cfg_data[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline moves unless a result is held
  logic en;
  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  // input stage: offset from the grid origin, below-origin and zero-step flags
  logic [COORD_BITS:0] dr_full, dc_full;
  logic                p0_valid;
  item_t               p0_item;
  coord_t              p0_dr, p0_dc;

  assign dr_full = {1'b0, query_radius} - {1'b0, radius_origin};
  assign dc_full = {1'b0, query_colat} - {1'b0, angle_origin};

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_item.func  <= func_t'(func);
      p0_item.addr  <= entry_address;
      p0_item.vals  <= {load_slope_long, load_slope_colat, load_slope_radius, load_log_density};
      p0_item.bad_r <= dr_full[COORD_BITS] || (radius_step == '0);
      p0_item.bad_c <= dc_full[COORD_BITS] || (angle_step == '0);
      p0_dr         <= dr_full[COORD_BITS-1:0];
      p0_dc         <= dc_full[COORD_BITS-1:0];
    end
  end

  // dividers, with the word carried alongside
  div_res_t div_r, div_c;

  gbi_divider u_div_r (
    .clk      (clk),
    .en       (en),
    .dividend (p0_dr),
    .divisor  (radius_step),
    .res      (div_r)
  );

  gbi_divider u_div_c (
    .clk      (clk),
    .en       (en),
    .dividend (p0_dc),
    .divisor  (angle_step),
    .res      (div_c)
  );

  logic [DIV_STAGES-1:0] sb_valid;
  item_t                 sb [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= '0;
    end else if (en) begin
      sb_valid <= {sb_valid[DIV_STAGES-2:0], p0_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= p0_item;
      for (int s = 1; s < DIV_STAGES; s++) begin
        sb[s] <= sb[s-1];
      end
    end
  end

  // stage A: range check, neighbour flags, base address
  item_t sb_last;
  cnt_t  rows_sat, cols_sat, i1x, j1x;
  logic  a_oob, a_hi_i, a_hi_j;
  addr_t a_base;

  assign sb_last  = sb[DIV_STAGES-1];
  assign rows_sat = (radius_count > cnt_t'(MAX_ROWS)) ? cnt_t'(MAX_ROWS) : radius_count;
  assign cols_sat = (angle_count > cnt_t'(MAX_COLS)) ? cnt_t'(MAX_COLS) : angle_count;
  assign i1x      = cnt_t'(div_r.idx);
  assign j1x      = cnt_t'(div_c.idx);
  assign a_oob    = sb_last.bad_r || sb_last.bad_c || div_r.over || div_c.over ||
                    (i1x >= rows_sat) || (j1x >= cols_sat);
  assign a_hi_i   = (i1x + cnt_t'(1)) < rows_sat;
  assign a_hi_j   = (j1x + cnt_t'(1)) < cols_sat;
  assign a_base   = addr_t'(i1x) * addr_t'(cols_sat) + addr_t'(j1x);

  logic  pa_valid, pa_oob, pa_hi_i, pa_hi_j;
  item_t pa_item;
  frac_t pa_fx, pa_fy;
  addr_t pa_base, pa_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_valid <= 1'b0;
    end else if (en) begin
      pa_valid <= sb_valid[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_item <= sb_last;
      pa_oob  <= a_oob;
      pa_hi_i <= a_hi_i;
      pa_hi_j <= a_hi_j;
      pa_fx   <= a_hi_i ? div_r.frac : '0;
      pa_fy   <= a_hi_j ? div_c.frac : '0;
      pa_base <= a_base;
      pa_cols <= addr_t'(cols_sat);
    end
  end

  // stage B: corner addresses, weights, status
  half_t   nfx, nfy;
  addr_t   b_a10, b_step_j;
  status_t b_status;

  assign nfx      = ONE_FRAC - half_t'(pa_fx);
  assign nfy      = ONE_FRAC - half_t'(pa_fy);
  assign b_step_j = addr_t'(pa_hi_j);
  assign b_a10    = pa_base + (pa_hi_i ? pa_cols : '0);

  always_comb begin
    priority if (pa_item.func == FUNC_LOAD) begin
      b_status = ST_LOADED;
    end else if (pa_oob) begin
      b_status = ST_NO_DATA;
    end else if (pa_hi_i && pa_hi_j) begin
      b_status = ST_BILINEAR;
    end else if (pa_hi_i || pa_hi_j) begin
      b_status = ST_LINEAR;
    end else begin
      b_status = ST_SINGLE;
    end
  end

  logic             pb_valid;
  func_t            pb_func;
  addr_t            pb_addr;
  entry_t           pb_vals;
  addr_t [3:0]      pb_raddr;
  weight_t [3:0]    pb_w;
  status_t          pb_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pb_valid <= 1'b0;
    end else if (en) begin
      pb_valid <= pa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pb_func     <= pa_item.func;
      pb_addr     <= pa_item.addr;
      pb_vals     <= pa_item.vals;
      pb_raddr[0] <= pa_base;
      pb_raddr[1] <= pa_base + b_step_j;
      pb_raddr[2] <= b_a10;
      pb_raddr[3] <= b_a10 + b_step_j;
      pb_w[0]     <= weight_t'(nfx) * weight_t'(nfy);
      pb_w[1]     <= weight_t'(nfx) * weight_t'(pa_fy);
      pb_w[2]     <= weight_t'(pa_fx) * weight_t'(nfy);
      pb_w[3]     <= weight_t'(pa_fx) * weight_t'(pa_fy);
      pb_status   <= b_status;
    end
  end

  // grid store: one copy per corner, every load writes all copies together
  logic   wr_en;
  entry_t rd [4];

  assign wr_en = en && pb_valid && (pb_func == FUNC_LOAD);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    gbi_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (pb_addr),
      .wdata (pb_vals),
      .re    (en),
      .raddr (pb_raddr[k]),
      .rdata (rd[k])
    );
  end

  // stage C: read data arrives, weights held alongside
  logic          pc_valid;
  weight_t [3:0] pc_w;
  status_t       pc_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_valid <= 1'b0;
    end else if (en) begin
      pc_valid <= pb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_w      <= pb_w;
      pc_status <= pb_status;
    end
  end

  // blend lanes, one per value
  logic [3:0][3:0][VALUE_BITS-1:0] lane_v;
  logic [3:0][VALUE_BITS-1:0]      lane_y;

  for (genvar f = 0; f < 4; f++) begin : g_lane
    for (genvar k = 0; k < 4; k++) begin : g_corner
      assign lane_v[f][k] = rd[k][f];
    end
    gbi_blend u_blend (
      .clk (clk),
      .en  (en),
      .w   (pc_w),
      .v   (lane_v[f]),
      .y   (lane_y[f])
    );
  end

  // status travels with the two blend stages
  logic    pd_valid, pe_valid;
  status_t pd_status, pe_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_valid <= 1'b0;
      pe_valid <= 1'b0;
    end else if (en) begin
      pd_valid <= pc_valid;
      pe_valid <= pd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_status <= pc_status;
      pe_status <= pd_status;
    end
  end

  // result register: loads and misses drop the blend and give fixed words
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= pe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= pe_status;
      unique case (pe_status)
        ST_LOADED: begin
          log_density  <= '0;
          slope_radius <= '0;
          slope_colat  <= '0;
          slope_long   <= '0;
        end
        ST_NO_DATA: begin
          log_density  <= VALUE_MIN;
          slope_radius <= '0;
          slope_colat  <= '0;
          slope_long   <= '0;
        end
        default: begin
          log_density  <= lane_y[0];
          slope_radius <= lane_y[1];
          slope_colat  <= lane_y[2];
          slope_long   <= lane_y[3];
        end
      endcase
    end
  end

endmodule
`default_nettype wire
